// File: rtl/stuffed_trainer_frame_decoder_macros.svh
// assertion macros for the stuffed trainer frame decoder
// expects clk and rst_n in the scope where the macros are used
`ifndef STUFFED_TRAINER_FRAME_DECODER_MACROS_SVH
`define STUFFED_TRAINER_FRAME_DECODER_MACROS_SVH

// property that must hold on every edge out of reset
`define SFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication checked on the next edge
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/stfd_pkg.sv
// types, constants and unpack helper for the stuffed trainer frame decoder
// no dependencies
`timescale 1ns / 1ps

package stfd_pkg;

    localparam int LINE_LENGTH_DEF = 32;
    localparam int FRAME_BYTES     = 14;
    localparam int CHANNELS        = 8;
    localparam int CHECK_BYTES     = 13;

    localparam logic [7:0] DELIM    = 8'h7E;
    localparam logic [7:0] ESCAPE   = 8'h7D;
    localparam logic [7:0] ESC_MASK = 8'h20;
    localparam logic [7:0] HEADER   = 8'h80;
    localparam logic [7:0] NEWLINE  = 8'h0A;

    typedef logic [7:0]  byte_t;
    typedef logic [11:0] chan_t;
    typedef logic [5:0]  index_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;
    typedef logic [CHANNELS-1:0][11:0]   chans_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_START    = 2'd1,
        ST_IN_FRAME = 2'd2,
        ST_ESCAPE   = 2'd3
    } parse_state_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_CSUM   = 2'd1,
        STAT_HEADER = 2'd2
    } status_t;

    // two 12-bit channels per three payload bytes
    function automatic chans_t unpack_channels(input frame_t fr);
        chans_t ch;
        for (int g = 0; g < CHANNELS / 2; g++) begin
            ch[2 * g]     = {fr[3 * g + 2][7:4], fr[3 * g + 1]};
            ch[2 * g + 1] = {fr[3 * g + 3][3:0], fr[3 * g + 2][3:0], fr[3 * g + 3][7:4]};
        end
        return ch;
    endfunction

endpackage

// File: rtl/stuffed_trainer_frame_decoder.sv
// byte-stuffed trainer frame deframer with xor check and channel unpack
// depends on stfd_pkg and stuffed_trainer_frame_decoder_macros.svh
`timescale 1ns / 1ps
`include "stuffed_trainer_frame_decoder_macros.svh"

// channel   handshake            payload
// -------   ------------------   -----------------------------------
// rx        rx_valid / rx_stall  rx_byte
// result    res_valid/res_stall  status, chan0 .. chan7
//
// one byte per cycle unless stalled: a beat lands in the input register, then the
// deframer, 13-byte xor and unpack run in one pass into the result register
// reset clears parse state, write index, frame store and kept channels
// rx_stall rises only while a byte waits in the input register and the result
// register holds a beat that the sink is stalling
// bytes that give no result still wait behind a stalled result beat

module stuffed_trainer_frame_decoder #(
    parameter int LINE_LENGTH = stfd_pkg::LINE_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [11:0] chan0,
    output logic [11:0] chan1,
    output logic [11:0] chan2,
    output logic [11:0] chan3,
    output logic [11:0] chan4,
    output logic [11:0] chan5,
    output logic [11:0] chan6,
    output logic [11:0] chan7
);

    localparam stfd_pkg::index_t LineLen   = 6'(LINE_LENGTH);
    localparam stfd_pkg::index_t FrameLen  = 6'(stfd_pkg::FRAME_BYTES);

    // input register
    logic                   pipe_valid_reg;
    stfd_pkg::byte_t        byte_reg;

    // deframer state
    stfd_pkg::parse_state_t state_reg, state_next;
    stfd_pkg::index_t       idx_reg, idx_next;
    stfd_pkg::frame_t       frame_reg, frame_next;
    stfd_pkg::chans_t       chan_reg, chan_next;

    // result register
    logic                   res_valid_reg;
    stfd_pkg::status_t      status_reg, status_next;

    logic                   adv;
    logic                   rx_fire;
    logic                   store_en;
    stfd_pkg::byte_t        store_val;
    stfd_pkg::byte_t        xsum;
    logic                   emit;

    // the stage moves whenever the result register is free or being taken
    assign adv      = !res_valid_reg || !res_stall;
    assign rx_stall = pipe_valid_reg && !adv;
    assign rx_fire  = rx_valid && !rx_stall;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        frame_next  = frame_reg;
        chan_next   = chan_reg;
        status_next = status_reg;
        store_en    = 1'b0;
        store_val   = byte_reg;
        xsum        = '0;
        emit        = 1'b0;
        if (pipe_valid_reg && adv)
        begin
            case (state_reg)
                stfd_pkg::ST_START:
                begin
                    if (byte_reg == stfd_pkg::DELIM)
                    begin
                        state_next = stfd_pkg::ST_IN_FRAME;
                        idx_next   = '0;
                    end
                    else
                    begin
                        store_en = 1'b1;
                    end
                end
                stfd_pkg::ST_IN_FRAME:
                begin
                    if (byte_reg == stfd_pkg::ESCAPE)
                    begin
                        state_next = stfd_pkg::ST_ESCAPE;
                    end
                    else if (byte_reg == stfd_pkg::DELIM)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        store_en = 1'b1;
                    end
                end
                stfd_pkg::ST_ESCAPE:
                begin
                    store_en   = 1'b1;
                    store_val  = byte_reg ^ stfd_pkg::ESC_MASK;
                    state_next = stfd_pkg::ST_IN_FRAME;
                end
                default:
                begin
                    if (byte_reg == stfd_pkg::DELIM)
                    begin
                        idx_next   = '0;
                        state_next = stfd_pkg::ST_START;
                    end
                    else
                    begin
                        store_en = 1'b1;
                    end
                end
            endcase

            // bytes past the frame store only advance the index
            if (store_en && (idx_reg < LineLen))
            begin
                if (idx_reg < FrameLen)
                begin
                    frame_next[idx_reg[3:0]] = store_val;
                end
                idx_next = idx_reg + 6'd1;
                if (store_val == stfd_pkg::NEWLINE)
                begin
                    idx_next = '0;
                end
            end

            // full frame: check and report, index left as is
            if (idx_next >= FrameLen)
            begin
                emit = 1'b1;
                for (int i = 0; i < stfd_pkg::CHECK_BYTES; i++)
                begin
                    xsum = xsum ^ frame_next[i];
                end
                if (xsum != frame_next[stfd_pkg::CHECK_BYTES])
                begin
                    status_next = stfd_pkg::STAT_CSUM;
                end
                else if (frame_next[0] != stfd_pkg::HEADER)
                begin
                    status_next = stfd_pkg::STAT_HEADER;
                end
                else
                begin
                    status_next = stfd_pkg::STAT_OK;
                    chan_next   = stfd_pkg::unpack_channels(frame_next);
                end
                state_next = stfd_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= stfd_pkg::ST_IDLE;
            idx_reg        <= '0;
            frame_reg      <= '{default: '0};
            chan_reg       <= '{default: '0};
        end
        else
        begin
            if (rx_fire)
            begin
                pipe_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                pipe_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
            idx_reg   <= idx_next;
            frame_reg <= frame_next;
            chan_reg  <= chan_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            byte_reg <= rx_byte;
        end
        if (emit)
        begin
            status_reg <= status_next;
        end
    end

    // kept channels only change when a result beat is loaded, so they
    // hold steady while that beat is stalled
    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign chan0     = chan_reg[0];
    assign chan1     = chan_reg[1];
    assign chan2     = chan_reg[2];
    assign chan3     = chan_reg[3];
    assign chan4     = chan_reg[4];
    assign chan5     = chan_reg[5];
    assign chan6     = chan_reg[6];
    assign chan7     = chan_reg[7];

    `SFD_ASSERT(a_idx_bound, idx_reg <= LineLen, "write index past line length")
    `SFD_ASSERT(a_stall_held, !rx_stall || (pipe_valid_reg && res_valid_reg),
        "rx stalled without a held byte and a held result")
    `SFD_ASSERT_NEXT(a_emit_idle, emit, res_valid_reg && state_reg == stfd_pkg::ST_IDLE,
        "result without return to idle")
    `SFD_ASSERT_NEXT(a_unpack, emit && status_next == stfd_pkg::STAT_OK,
        chan_reg[0] == {frame_reg[2][7:4], frame_reg[1]},
        "accepted frame channel 0 mismatch")

endmodule

// File: bench/tb_stuffed_trainer_frame_decoder.sv
// self-checking stuffed trainer frame decoder bench: directed beats, then random frames and noise
// depends on stfd_pkg and the stuffed_trainer_frame_decoder rtl
`timescale 1ns / 1ps

module tb_stuffed_trainer_frame_decoder;

    import stfd_pkg::*;

    localparam int LINE_LEN = LINE_LENGTH_DEF;
    localparam int RANDOM_BYTES = 1350;
    localparam int PRINT_CAP = 40;

    // one result beat: status plus the eight kept channels, chan0 in the low slot
    typedef struct packed {
        status_t                   st;
        logic [CHANNELS-1:0][11:0] ch;
    } frame_report_t;

    // directed row: a byte, and for rows whose result is obvious the typed-in answer
    // (all eight channels share one value in every such row)
    typedef struct packed {
        byte_t   data;
        bit      pinned;
        status_t st;
        chan_t   ch;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  status;
    logic [11:0] chan0;
    logic [11:0] chan1;
    logic [11:0] chan2;
    logic [11:0] chan3;
    logic [11:0] chan4;
    logic [11:0] chan5;
    logic [11:0] chan6;
    logic [11:0] chan7;

    // shadow of the deframer: parse state, write index, frame store, kept channels
    parse_state_t dec_state;
    index_t       dec_index;
    byte_t        dec_frame [FRAME_BYTES];
    chan_t        dec_chans [CHANNELS];

    frame_report_t frame_reports [$];
    stim_row_t     directed_rows [$];

    int mismatches;
    int bytes_sent;
    int reports_seen;
    int frames_good;
    bit rx_quiet;

    stuffed_trainer_frame_decoder #(
        .LINE_LENGTH(LINE_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .status(status),
        .chan0(chan0),
        .chan1(chan1),
        .chan2(chan2),
        .chan3(chan3),
        .chan4(chan4),
        .chan5(chan5),
        .chan6(chan6),
        .chan7(chan7)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs on a handshake
    initial
    begin
        #8_000_000;
        $display("run stopped at its time limit");
        $display("tb: failure");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // one byte through the shadow deframer; returns 1 when it triggers a check
    function automatic bit deframe_byte(input byte_t b, output frame_report_t rep);
        byte_t val;
        byte_t sum;
        byte_t lo;
        byte_t mid;
        byte_t hi;
        bit    keep;
        keep = 1'b0;
        val = b;
        rep = '0;
        case (dec_state)
            ST_START:
            begin
                if (b == DELIM)
                begin
                    dec_state = ST_IN_FRAME;
                    dec_index = '0;
                end
                else
                    keep = 1'b1;
            end
            ST_IN_FRAME:
            begin
                if (b == ESCAPE)
                    dec_state = ST_ESCAPE;
                else if (b == DELIM)
                    dec_index = '0;
                else
                    keep = 1'b1;
            end
            ST_ESCAPE:
            begin
                // escaped delimiter included: flip bit 5 and store
                val = b ^ ESC_MASK;
                keep = 1'b1;
                dec_state = ST_IN_FRAME;
            end
            default:
            begin
                if (b == DELIM)
                begin
                    dec_index = '0;
                    dec_state = ST_START;
                end
                else
                    keep = 1'b1;
            end
        endcase
        // index saturates at the line length, bytes past the store only count
        if (keep && dec_index < LINE_LEN)
        begin
            if (dec_index < FRAME_BYTES)
                dec_frame[dec_index[3:0]] = val;
            dec_index = dec_index + 6'd1;
            if (val == NEWLINE)
                dec_index = '0;
        end
        if (dec_index < FRAME_BYTES)
            return 1'b0;
        sum = '0;
        for (int i = 0; i < CHECK_BYTES; i++)
            sum = sum ^ dec_frame[i];
        if (sum != dec_frame[CHECK_BYTES])
            rep.st = STAT_CSUM;
        else if (dec_frame[0] != HEADER)
            rep.st = STAT_HEADER;
        else
        begin
            rep.st = STAT_OK;
            for (int g = 0; g < CHANNELS / 2; g++)
            begin
                lo  = dec_frame[3 * g + 1];
                mid = dec_frame[3 * g + 2];
                hi  = dec_frame[3 * g + 3];
                dec_chans[2 * g]     = {mid[7:4], lo};
                dec_chans[2 * g + 1] = {hi[3:0], mid[3:0], hi[7:4]};
            end
        end
        // index is left alone, so idle bytes repeat the check
        dec_state = ST_IDLE;
        for (int i = 0; i < CHANNELS; i++)
            rep.ch[i] = dec_chans[i];
        return 1'b1;
    endfunction

    // drive one beat, wait for it to be taken, then log what it should produce
    task automatic push_byte(input byte_t b, input bit pinned, input frame_report_t pin_rep);
        frame_report_t rep;
        int            gap;
        bit            hit;
        gap = rx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= byte_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        hit = deframe_byte(b, rep);
        if (pinned)
            frame_reports.push_back(pin_rep);
        else if (hit)
            frame_reports.push_back(rep);
        bytes_sent++;
    endtask

    task automatic send_plain(input byte_t b);
        push_byte(b, 1'b0, '0);
    endtask

    // payload byte biased toward the stuffing corner values
    function automatic byte_t pick_payload();
        byte_t b;
        case ($urandom_range(0, 15))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = DELIM;
            3: b = ESCAPE;
            4: b = DELIM ^ ESC_MASK;
            default: b = byte_t'($urandom);
        endcase
        // a stored newline kills the frame, keep most frames alive
        if (b == NEWLINE && $urandom_range(0, 3) != 0)
            b = 8'h0B;
        return b;
    endfunction

    // mostly well-formed stuffed frames, some truncated, unstuffed, with a bad header or bad checksum,
    // often followed by idle bytes that retrigger the check
    task automatic send_random_frame();
        byte_t raw [FRAME_BYTES];
        byte_t sum;
        byte_t b;
        int    style;
        int    cut;
        int    tail;
        int    r;
        raw[0] = ($urandom_range(0, 9) < 8) ? HEADER : byte_t'($urandom);
        for (int i = 1; i < FRAME_BYTES; i++)
            raw[i] = pick_payload();
        sum = '0;
        for (int i = 0; i < CHECK_BYTES; i++)
            sum = sum ^ raw[i];
        if ($urandom_range(0, 9) < 8)
            raw[CHECK_BYTES] = sum;
        rx_quiet = ($urandom_range(0, 4) == 0);
        style = $urandom_range(0, 9);
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
        // two delimiters land in-frame with the index at zero, unless the first one, escaped, fills the store
        if (style < 8)
        begin
            send_plain(DELIM);
            send_plain(DELIM);
        end
        else if (style == 8)
            send_plain(DELIM);
        for (int i = 0; i < cut; i++)
        begin
            if (style < 8 && (raw[i] == DELIM || raw[i] == ESCAPE || $urandom_range(0, 19) == 0))
            begin
                send_plain(ESCAPE);
                send_plain(raw[i] ^ ESC_MASK);
            end
            else
                send_plain(raw[i]);
        end
        // long tails run the index up to the line length
        r = $urandom_range(0, 9);
        tail = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(15, 24);
        for (int i = 0; i < tail; i++)
        begin
            b = byte_t'($urandom);
            if (b == DELIM)
                b = 8'h00;
            send_plain(b);
        end
    endtask

    task automatic send_noise();
        int    n;
        byte_t b;
        rx_quiet = ($urandom_range(0, 3) == 0);
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 9) == 0) ? DELIM : byte_t'($urandom);
            send_plain(b);
        end
    endtask

    function automatic void add_bytes(input byte_t b, input int n);
        stim_row_t row;
        row = '{data: b, pinned: 1'b0, st: STAT_OK, ch: '0};
        for (int i = 0; i < n; i++)
            directed_rows.push_back(row);
    endfunction

    function automatic void add_check(input byte_t b, input status_t st, input chan_t ch);
        directed_rows.push_back('{data: b, pinned: 1'b1, st: st, ch: ch});
    endfunction

    // sink side: random stall runs with quiet stretches in between
    initial
    begin
        int stall_len;
        res_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b0;
                repeat ($urandom_range(30, 150)) @(posedge clk);
            end
            else
            begin
                stall_len = pick_gap();
                if (stall_len > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // result beats are compared against the oldest expectation, field by field
    always @(posedge clk)
    begin : watch_results
        frame_report_t             want;
        logic [CHANNELS-1:0][11:0] got_ch;
        if (rst_n && res_valid && !res_stall)
        begin
            got_ch = {chan7, chan6, chan5, chan4, chan3, chan2, chan1, chan0};
            reports_seen++;
            if (status == STAT_OK)
                frames_good++;
            if (frame_reports.size() == 0)
                flag_mismatch($sformatf("result beat with nothing expected, status %0d", status));
            else
            begin
                want = frame_reports.pop_front();
                if (status !== want.st)
                    flag_mismatch($sformatf("status got %0d want %0d", status, want.st));
                for (int i = 0; i < CHANNELS; i++)
                    if (got_ch[i] !== want.ch[i])
                        flag_mismatch($sformatf("chan%0d got %03h want %03h",
                                                i, got_ch[i], want.ch[i]));
            end
        end
    end

    initial
    begin
        int drain;
        mismatches   = 0;
        bytes_sent   = 0;
        reports_seen = 0;
        frames_good  = 0;
        rx_quiet     = 1'b0;
        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = 8'h00;

        // shadow reset: idle, index zero, store and channels cleared
        dec_state = ST_IDLE;
        dec_index = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
            dec_frame[i] = '0;
        for (int i = 0; i < CHANNELS; i++)
            dec_chans[i] = '0;

        // after reset: fourteen zero bytes in idle fill the store, checksum holds,
        // header is wrong, channels still at reset
        add_bytes(8'h00, 13);
        add_check(8'h00, STAT_HEADER, 12'h000);
        // clean frame with an all-ones payload, every channel saturates
        add_bytes(DELIM, 2);
        add_bytes(HEADER, 1);
        add_bytes(8'hFF, 12);
        add_check(HEADER, STAT_OK, 12'hFFF);
        // idle byte after the check repeats it with the same store
        add_check(8'h00, STAT_OK, 12'hFFF);
        // newline clears the index, escaped delimiter and escape,
        // delimiter right after an escape, then a bad checksum
        add_bytes(DELIM, 2);
        add_bytes(HEADER, 1);
        add_bytes(NEWLINE, 1);
        add_bytes(HEADER, 1);
        add_bytes(ESCAPE, 1);
        add_bytes(DELIM ^ ESC_MASK, 1);
        add_bytes(ESCAPE, 1);
        add_bytes(ESCAPE ^ ESC_MASK, 1);
        add_bytes(ESCAPE, 1);
        add_bytes(DELIM, 1);
        add_bytes(8'h00, 9);
        add_check(8'h01, STAT_CSUM, 12'hFFF);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_byte(directed_rows[i].data, directed_rows[i].pinned,
                      '{st: directed_rows[i].st, ch: {CHANNELS{directed_rows[i].ch}}});

        // random part: mostly frames, some raw noise
        while (bytes_sent < directed_rows.size() + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 99) < 85)
                send_random_frame();
            else
                send_noise();
        end
        rx_valid <= 1'b0;

        // drain, then wait on so that the pipe can show any stray beat
        drain = 0;
        while (frame_reports.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (frame_reports.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", frame_reports.size()));

        $display("sent %0d bytes, checked %0d result beats, %0d of them accepted frames",
                 bytes_sent, reports_seen, frames_good);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/stfd_pkg.sv
rtl/stuffed_trainer_frame_decoder.sv
bench/tb_stuffed_trainer_frame_decoder.sv
